/* src/hbsd_pkg.sv */
`default_nettype none

package hbsd_pkg;

  // Field widths fixed by the stream format.
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int WORD_W = 16;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 4;
  localparam int LEFT_W = 3;

  // Rows per first-level priority group in the code table.
  localparam int GROUP_SIZE = 16;
  localparam int GRP_W      = 4;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] BYTE_BITS = 4'd8;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_DECODE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_DECODE,
    OP_CLEAR
  } hbsd_op_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    hbsd_op_t              op;
    logic [SYM_W-1:0]      sym;
    logic [LEN_W-1:0]      len;
    logic [WORD_W-1:0]     word;
    logic [DATA_W-1:0]     data;
    logic [CNT_W-1:0]      count;
  } hbsd_item_t;

  // Control from the sequencer to the code table.
  typedef struct packed {
    logic                  cmp_en;
    logic                  wr_en;
    logic [SYM_W-1:0]      wr_sym;
    logic [LEN_W-1:0]      wr_len;
    logic [WORD_W-1:0]     wr_word;
  } hbsd_cam_ctl_t;

  // Outcome of one table search.
  typedef struct packed {
    logic                  hit;
    logic [SYM_W-1:0]      symbol;
  } hbsd_match_t;

endpackage

`default_nettype wire

/* src/hbsd_in_if.sv */
`default_nettype none

interface hbsd_in_if import hbsd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [SYM_W-1:0]  symbol;
  logic [4:0]        code_len;
  logic [WORD_W-1:0] code_word;
  logic [DATA_W-1:0] data_byte;
  logic [CNT_W-1:0]  bit_count;

  modport source (
    output valid, cmd, symbol, code_len, code_word, data_byte, bit_count,
    input  ready
  );

  modport sink (
    input  valid, cmd, symbol, code_len, code_word, data_byte, bit_count,
    output ready
  );
endinterface

`default_nettype wire

/* src/hbsd_out_if.sv */
`default_nettype none

interface hbsd_out_if import hbsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic             overflow;
  logic             last;

  modport source (
    output valid, out_symbol, overflow, last,
    input  ready
  );

  modport sink (
    input  valid, out_symbol, overflow, last,
    output ready
  );
endinterface

`default_nettype wire

/* src/hbsd_front.sv */
`default_nettype none

module hbsd_front import hbsd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16,
  parameter int NUM_SYMBOLS  = 256
) (
  hbsd_in_if.sink    items,
  output logic       push_valid,
  input  logic       push_ready,
  output hbsd_item_t push_item
);

  logic             keep;
  logic [LEN_W-1:0] len_ok;
  logic [WORD_W-1:0] word_mask;

  // Items are taken whenever the queue has room; those with no effect are dropped here.
  assign items.ready = push_ready;
  assign push_valid  = items.valid && keep;

  // Classify the command and normalise its fields.
  always_comb begin
    len_ok    = {1'b0, items.code_len};
    if (len_ok > LEN_W'(MAX_CODE_LEN)) begin
      len_ok = '0;
    end
    word_mask = ~({WORD_W{1'b1}} << len_ok);

    push_item.sym   = items.symbol;
    push_item.len   = len_ok;
    push_item.word  = items.code_word & word_mask;
    push_item.data  = items.data_byte;
    push_item.count = (items.bit_count > BYTE_BITS) ? BYTE_BITS : items.bit_count;
    push_item.op    = OP_CLEAR;
    keep            = 1'b0;

    case (items.cmd)
      CMD_LOAD: begin
        push_item.op = OP_LOAD;
        keep         = ({1'b0, items.symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
      end
      CMD_DECODE: begin
        push_item.op = OP_DECODE;
        keep         = (items.bit_count != '0);
      end
      CMD_CLEAR: begin
        push_item.op = OP_CLEAR;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/hbsd_queue.sv */
`default_nettype none

module hbsd_queue import hbsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  hbsd_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output hbsd_item_t pop_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  hbsd_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  // No transfer is taken while reset is held, since the fill level is being cleared.
  assign push_ready = !rst && (fill != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill <= CNT_QW'(fill + 1'b1);
      end else if (do_pop && !do_push) begin
        fill <= CNT_QW'(fill - 1'b1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* src/hbsd_cam.sv */
`default_nettype none

module hbsd_cam import hbsd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hbsd_cam_ctl_t                    ctl,
  input  logic [MAX_CODE_LEN-1:0]          cand_bits,
  input  logic [$clog2(MAX_CODE_LEN+1)-1:0] cand_len,
  output hbsd_match_t                      match
);

  localparam int LW   = $clog2(MAX_CODE_LEN + 1);
  localparam int SW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int WIDE = (MAX_CODE_LEN > WORD_W) ? MAX_CODE_LEN : WORD_W;
  localparam int NG   = (NUM_SYMBOLS + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [LW-1:0]           table_len  [NUM_SYMBOLS];
  logic [MAX_CODE_LEN-1:0] table_word [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]  row_hit;
  logic [NG-1:0]           grp_hit_d;
  logic [GRP_W-1:0]        grp_idx_d [NG];
  logic [NG-1:0]           grp_hit;
  logic [GRP_W-1:0]        grp_idx   [NG];
  logic [WIDE-1:0]         wr_word_ext;

  assign wr_word_ext = WIDE'(ctl.wr_word);

  // Lengths reset to zero so every symbol starts unused.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        table_len[s] <= '0;
      end
    end else if (ctl.wr_en) begin
      table_len[ctl.wr_sym[SW-1:0]] <= LW'(ctl.wr_len);
    end
  end

  // Code words are only compared once their length has been written.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      table_word[ctl.wr_sym[SW-1:0]] <= wr_word_ext[MAX_CODE_LEN-1:0];
    end
  end

  // Every row compares against the candidate in parallel.
  always_comb begin
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      row_hit[s] = (table_len[s] != '0) && (table_len[s] == cand_len) &&
                   (table_word[s] == cand_bits);
    end
  end

  // First level: the highest matching row within each group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
        if ((g * GROUP_SIZE + i < NUM_SYMBOLS) && row_hit[g * GROUP_SIZE + i]) begin
          grp_hit_d[g] = 1'b1;
          grp_idx_d[g] = GRP_W'(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      grp_hit <= grp_hit_d;
      for (int g = 0; g < NG; g++) begin
        grp_idx[g] <= grp_idx_d[g];
      end
    end
  end

  // Second level: the highest group with a hit wins.
  always_comb begin
    match.hit    = 1'b0;
    match.symbol = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp_hit[g]) begin
        match.hit    = 1'b1;
        match.symbol = SYM_W'(g * GROUP_SIZE) | SYM_W'(grp_idx[g]);
      end
    end
  end

endmodule

`default_nettype wire

/* src/hbsd_back.sv */
`default_nettype none

module hbsd_back import hbsd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  hbsd_item_t                        q_item,
  output hbsd_cam_ctl_t                     cam_ctl,
  output logic [MAX_CODE_LEN-1:0]           cand_bits,
  output logic [$clog2(MAX_CODE_LEN+1)-1:0] cand_len,
  input  hbsd_match_t                       match,
  hbsd_out_if.source                        results
);

  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SEL,
    S_FLUSH
  } state_t;

  state_t                  state;
  logic [MAX_CODE_LEN-1:0] acc_bits;
  logic [LW-1:0]           acc_len;
  logic [MAX_CODE_LEN-1:0] acc_bits_next;
  logic [LW-1:0]           acc_len_next;
  logic [DATA_W-1:0]       dsh;
  logic [LEFT_W-1:0]       bits_left;
  logic                    pend_valid;
  logic [SYM_W-1:0]        pend_symbol;
  logic                    pend_ovf;
  logic                    res_valid;
  logic [SYM_W-1:0]        res_symbol;
  logic                    res_ovf;
  logic                    res_last;
  logic [DATA_W-1:0]       first_aligned;
  logic [MAX_CODE_LEN:0]   idle_shift;
  logic [MAX_CODE_LEN:0]   sel_shift;
  logic                    produce;
  logic                    sel_stall;
  logic                    out_free;
  logic                    res_load;

  assign results.valid      = res_valid;
  assign results.out_symbol = res_symbol;
  assign results.overflow   = res_ovf;
  assign results.last       = res_last;

  // Bit stepping, result decision and table control.
  always_comb begin
    q_ready       = (state == S_IDLE);
    first_aligned = q_item.data << (BYTE_BITS - q_item.count);
    idle_shift    = {acc_bits, first_aligned[DATA_W-1]};
    produce       = match.hit || (cand_len == LW'(MAX_CODE_LEN));
    acc_bits_next = produce ? '0 : cand_bits;
    acc_len_next  = produce ? '0 : cand_len;
    sel_shift     = {acc_bits_next, dsh[DATA_W-1]};
    out_free      = !res_valid || results.ready;
    sel_stall     = produce && pend_valid && !out_free;
    // The output register takes a new result in this cycle.
    res_load      = ((state == S_SEL) && !sel_stall && produce && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && out_free);

    cam_ctl.cmp_en  = (state == S_CMP);
    cam_ctl.wr_en   = (state == S_IDLE) && q_valid && (q_item.op == OP_LOAD);
    cam_ctl.wr_sym  = q_item.sym;
    cam_ctl.wr_len  = q_item.len;
    cam_ctl.wr_word = q_item.word;
  end

  // Sequencer, accumulator, pending result and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      acc_bits   <= '0;
      acc_len    <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && results.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_DECODE: begin
                dsh       <= first_aligned << 1;
                bits_left <= LEFT_W'(q_item.count - 1'b1);
                cand_bits <= idle_shift[MAX_CODE_LEN-1:0];
                cand_len  <= LW'(acc_len + 1'b1);
                state     <= S_CMP;
              end
              OP_CLEAR: begin
                acc_bits <= '0;
                acc_len  <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CMP: begin
          state <= S_SEL;
        end
        S_SEL: begin
          if (!sel_stall) begin
            // A new result pushes the held one out; it is not the last of the byte.
            if (produce) begin
              if (pend_valid) begin
                res_valid  <= 1'b1;
                res_symbol <= pend_symbol;
                res_ovf    <= pend_ovf;
                res_last   <= 1'b0;
              end
              pend_valid  <= 1'b1;
              pend_symbol <= match.hit ? match.symbol : '0;
              pend_ovf    <= !match.hit;
            end
            acc_bits <= acc_bits_next;
            acc_len  <= acc_len_next;
            if (bits_left != '0) begin
              cand_bits <= sel_shift[MAX_CODE_LEN-1:0];
              cand_len  <= LW'(acc_len_next + 1'b1);
              dsh       <= dsh << 1;
              bits_left <= LEFT_W'(bits_left - 1'b1);
              state     <= S_CMP;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          // The held result is the last one of the byte.
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res_valid  <= 1'b1;
            res_symbol <= pend_symbol;
            res_ovf    <= pend_ovf;
            res_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/huffman_bit_serial_decoder.sv */
// Channel   Port     Role    Payload
// input     items    sink    cmd, symbol, code_len, code_word, data_byte, bit_count
// output    results  source  out_symbol, overflow, last
//
// A load or a clear is handled in the back end's idle state; a decode steps through
// its bits one at a time, each with a table compare and the two-level priority select,
// and then a flush state releases the last result.
// Reset clears the code table lengths, the accumulator, the queue and all valids.
// Inputs are taken into a two-entry queue while the back end works; the back end
// waits only when a result has to enter the output register while that is still full.
`default_nettype none

module huffman_bit_serial_decoder import hbsd_pkg::*; #(
  parameter int MAX_CODE_LEN = 16,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  hbsd_in_if.sink     items,
  hbsd_out_if.source  results
);

  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  logic                    push_valid;
  logic                    push_ready;
  hbsd_item_t              push_item;
  logic                    q_valid;
  logic                    q_ready;
  hbsd_item_t              q_item;
  hbsd_cam_ctl_t           cam_ctl;
  logic [MAX_CODE_LEN-1:0] cand_bits;
  logic [LW-1:0]           cand_len;
  hbsd_match_t             match;

  // Front end: classify and drop commands with no effect.
  hbsd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_front (
    .items      (items),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // Command queue between the two halves.
  hbsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // Code table with parallel compare.
  hbsd_cam #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_cam (
    .clk       (clk),
    .rst       (rst),
    .ctl       (cam_ctl),
    .cand_bits (cand_bits),
    .cand_len  (cand_len),
    .match     (match)
  );

  // Back end: bit-serial sequencer and result output.
  hbsd_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .cam_ctl   (cam_ctl),
    .cand_bits (cand_bits),
    .cand_len  (cand_len),
    .match     (match),
    .results   (results)
  );

`ifndef SYNTHESIS
  // A table write only happens on a transfer of a load out of the queue.
  a_write_on_pop: assert property (@(posedge clk) disable iff (rst)
    cam_ctl.wr_en |-> (q_valid && q_ready))
    else $error("table written without a queue transfer");

  // Each compare is followed by a select cycle, never by another compare.
  a_cmp_single: assert property (@(posedge clk) disable iff (rst)
    cam_ctl.cmp_en |=> !cam_ctl.cmp_en)
    else $error("compare issued on consecutive cycles");

  // Decodes reaching the back end carry a bit count between one and eight.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && (q_item.op == OP_DECODE)) |->
      ((q_item.count != '0) && (q_item.count <= BYTE_BITS)))
    else $error("decode with bit count out of range");

  // An overflow result carries symbol zero.
  a_ovf_symbol: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.overflow) |-> (results.out_symbol == '0))
    else $error("overflow result with nonzero symbol");
`endif

endmodule

`default_nettype wire

/* sim/tb_huffman_bit_serial_decoder.sv */
`timescale 1ns / 1ps

module tb_huffman_bit_serial_decoder;
  import hbsd_pkg::*;

  localparam int MAX_CODE_LEN  = 16;
  localparam int NUM_SYMBOLS   = 256;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_GAP       = 19;

  // The command field can also carry a code that the block does nothing with.
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [4:0]  len;
    logic [15:0] word;
    logic [7:0]  data;
    logic [3:0]  cnt;
  } stream_item_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       ovf;
    logic       last;
  } decoded_t;

  // Shadow copy of the code table and accumulator, with the queue of symbols
  // that the block still owes us.
  class decode_scoreboard;
    logic [4:0]  code_len_tbl [NUM_SYMBOLS];
    logic [15:0] code_word_tbl [NUM_SYMBOLS];
    logic [15:0] acc_bits;
    logic [4:0]  acc_len;
    decoded_t    expected_q[$];
    int          failures;

    function new();
      foreach (code_len_tbl[i]) begin
        code_len_tbl[i]  = '0;
        code_word_tbl[i] = '0;
      end
      acc_bits = '0;
      acc_len  = '0;
      failures = 0;
    endfunction

    static function logic [15:0] len_mask(logic [4:0] n);
      logic [31:0] m;
      m = (32'd1 << n) - 32'd1;
      return m[15:0];
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // Scan from the top symbol down so that the higher of two shared codes wins.
    function int lookup_symbol();
      for (int s = NUM_SYMBOLS - 1; s >= 0; s--) begin
        if (code_len_tbl[s] != 0 && code_len_tbl[s] == acc_len &&
            code_word_tbl[s] == (acc_bits & len_mask(acc_len)))
          return s;
      end
      return -1;
    endfunction

    function void note_input(stream_item_t it);
      decoded_t   batch[$];
      decoded_t   r;
      int         hit;
      int         n;
      logic [4:0] len;
      case (it.cmd)
        CMD_LOAD: begin
          len = (it.len > MAX_CODE_LEN) ? 5'd0 : it.len;
          code_len_tbl[it.sym]  = len;
          code_word_tbl[it.sym] = it.word & len_mask(len);
        end
        CMD_CLEAR: begin
          acc_bits = '0;
          acc_len  = '0;
        end
        CMD_DECODE: begin
          n = (it.cnt > BYTE_BITS) ? int'(BYTE_BITS) : int'(it.cnt);
          for (int i = n; i > 0; i--) begin
            acc_bits = {acc_bits[14:0], it.data[i-1]};
            acc_len  = acc_len + 5'd1;
            hit = lookup_symbol();
            if (hit >= 0) begin
              r.sym  = hit[7:0];
              r.ovf  = 1'b0;
              r.last = 1'b0;
              batch.push_back(r);
              acc_bits = '0;
              acc_len  = '0;
            end else if (acc_len >= MAX_CODE_LEN) begin
              r.sym  = '0;
              r.ovf  = 1'b1;
              r.last = 1'b0;
              batch.push_back(r);
              acc_bits = '0;
              acc_len  = '0;
            end
          end
          if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
          foreach (batch[i]) expected_q.push_back(batch[i]);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(decoded_t got);
      decoded_t exp;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: symbol %0d overflow %0b last %0b",
                       got.sym, got.ovf, got.last));
        return;
      end
      exp = expected_q.pop_front();
      if (exp.sym != got.sym || exp.ovf != got.ovf || exp.last != got.last)
        flag($sformatf({"result mismatch: symbol exp %0d got %0d, ",
                        "overflow exp %0b got %0b, last exp %0b got %0b"},
                       exp.sym, got.sym, exp.ovf, got.ovf, exp.last, got.last));
    endfunction

    function void close_out();
      if (expected_q.size() != 0)
        flag($sformatf("%0d expected results never arrived", expected_q.size()));
    endfunction
  endclass

  logic clk;
  logic rst;

  hbsd_in_if  item_bus ();
  hbsd_out_if result_bus ();

  huffman_bit_serial_decoder #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (item_bus),
    .results(result_bus)
  );

  decode_scoreboard sb;
  int               sent_count;
  int               ready_hold;
  int               cycle_count;
  bit               sender_quiet;
  bit               receiver_quiet;
  int               live_syms[$];
  int               leaf_len[$];
  logic [15:0]      leaf_word[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // Grow a complete prefix code by splitting leaves; half the time the newest
  // leaf is split again, which drives some codes towards the maximum length.
  function automatic void build_code_tree(int leaves);
    int          pick;
    int          l;
    logic [15:0] w;
    leaf_word.delete();
    leaf_len.delete();
    leaf_word.push_back(16'd0);
    leaf_len.push_back(0);
    while (leaf_word.size() < leaves) begin
      pick = ($urandom_range(0, 1) == 1) ? leaf_word.size() - 1
                                         : int'($urandom_range(0, leaf_word.size() - 1));
      while (leaf_len[pick] >= MAX_CODE_LEN)
        pick = $urandom_range(0, leaf_word.size() - 1);
      w = leaf_word[pick];
      l = leaf_len[pick];
      leaf_word.delete(pick);
      leaf_len.delete(pick);
      leaf_word.push_back({w[14:0], 1'b0});
      leaf_len.push_back(l + 1);
      leaf_word.push_back({w[14:0], 1'b1});
      leaf_len.push_back(l + 1);
    end
  endfunction

  // One transfer on the input channel; returns at the falling edge after it.
  task automatic send_item(logic [1:0] cmd, logic [7:0] sym, logic [4:0] len,
                           logic [15:0] word, logic [7:0] data, logic [3:0] cnt);
    int           gap;
    stream_item_t it;
    gap = pick_gap(sender_quiet);
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_bus.cmd       <= cmd;
    item_bus.symbol    <= sym;
    item_bus.code_len  <= len;
    item_bus.code_word <= word;
    item_bus.data_byte <= data;
    item_bus.bit_count <= cnt;
    item_bus.valid     <= 1'b1;
    do @(posedge clk); while (!item_bus.ready);
    it.cmd  = cmd;
    it.sym  = sym;
    it.len  = len;
    it.word = word;
    it.data = data;
    it.cnt  = cnt;
    sb.note_input(it);
    sent_count++;
    @(negedge clk);
  endtask

  // Fields that a command does not use still carry random values.
  task automatic load_entry(logic [7:0] sym, logic [4:0] len, logic [15:0] word);
    send_item(CMD_LOAD, sym, len, word, 8'($urandom), 4'($urandom));
  endtask

  task automatic decode_byte(logic [7:0] data, logic [3:0] cnt);
    send_item(CMD_DECODE, 8'($urandom), 5'($urandom), 16'($urandom), data, cnt);
  endtask

  task automatic send_other(logic [1:0] cmd);
    send_item(cmd, 8'($urandom), 5'($urandom), 16'($urandom), 8'($urandom),
              4'($urandom));
  endtask

  // Hold the sender off until every outstanding symbol has been returned.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Output sink: ready drops for a random number of cycles after each transfer.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_bus.ready <= 1'b0;
      end else if (ready_hold > 0) begin
        result_bus.ready <= 1'b0;
        ready_hold--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Output monitor: every transfer is checked against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    decoded_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.sym  = result_bus.out_symbol;
      got.ovf  = result_bus.overflow;
      got.last = result_bus.last;
      sb.check_result(got);
      ready_hold = pick_gap(receiver_quiet);
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int          s;
    int          n;
    int          r;
    int          directed_total;
    int          round_no;
    bit          sparse;
    bit          taken[NUM_SYMBOLS];
    logic [15:0] word;
    logic [15:0] m;

    sb = new();
    sent_count     = 0;
    ready_hold     = 0;
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    rst                = 1'b1;
    item_bus.valid     = 1'b0;
    item_bus.cmd       = CMD_LOAD;
    item_bus.symbol    = '0;
    item_bus.code_len  = '0;
    item_bus.code_word = '0;
    item_bus.data_byte = '0;
    item_bus.bit_count = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: a small table with a shared code, masked words, an
    // overlong length and a maximum-length code.
    load_entry(8'd255, 5'd1, 16'hFFFE);
    load_entry(8'd0, 5'd2, 16'h0002);
    load_entry(8'd1, 5'd2, 16'hFFFE);
    load_entry(8'd128, 5'd16, 16'hFFFF);
    load_entry(8'd2, 5'd31, 16'h0001);
    load_entry(8'd3, 5'd0, 16'h0000);
    load_entry(8'd4, 5'd17, 16'h0003);
    decode_byte(8'h00, BYTE_BITS);
    decode_byte(8'hAA, BYTE_BITS);
    decode_byte(8'hFF, BYTE_BITS);
    decode_byte(8'hFF, 4'd15);
    decode_byte(8'h55, 4'd0);
    decode_byte(8'h01, 4'd1);
    send_other(CMD_CLEAR);
    decode_byte(8'h02, 4'd2);
    send_other(CMD_NONE);
    // Without the long code a run of ones can only end in an overflow.
    load_entry(8'd128, 5'd0, 16'hFFFF);
    decode_byte(8'hFF, BYTE_BITS);
    decode_byte(8'hFF, BYTE_BITS);
    decode_byte(8'hC0, BYTE_BITS);
    send_other(CMD_CLEAR);
    decode_byte(8'h00, 4'd9);
    load_entry(8'd255, 5'd0, 16'h0000);
    decode_byte(8'h00, BYTE_BITS);
    drain_results();
    live_syms = '{255, 0, 1, 128, 2, 3, 4};
    directed_total = sent_count;

    // Random part: each round retires most old codes, loads a fresh prefix
    // code (sometimes with holes), adds a little noise and then streams bytes.
    round_no = 0;
    while (sent_count < directed_total + RANDOM_ITEMS) begin
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);

      n = live_syms.size();
      repeat (n) begin
        s = live_syms.pop_front();
        if ($urandom_range(0, 3) != 0) load_entry(s[7:0], 5'd0, 16'($urandom));
        else live_syms.push_back(s);
      end

      foreach (taken[i]) taken[i] = 1'b0;
      build_code_tree($urandom_range(2, 24));
      sparse = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < leaf_len.size(); k++) begin
        if (!(sparse && $urandom_range(0, 1) == 1)) begin
          do s = $urandom_range(0, NUM_SYMBOLS - 1); while (taken[s]);
          taken[s] = 1'b1;
          m = decode_scoreboard::len_mask(5'(leaf_len[k]));
          word = 16'($urandom);
          word = (word & ~m) | leaf_word[k];
          load_entry(s[7:0], 5'(leaf_len[k]), word);
          live_syms.push_back(s);
        end
      end

      repeat ($urandom_range(0, 3)) begin
        s = $urandom_range(0, NUM_SYMBOLS - 1);
        load_entry(s[7:0], 5'($urandom_range(0, 31)), 16'($urandom));
        live_syms.push_back(s);
      end

      repeat ($urandom_range(8, 30)) begin
        r = $urandom_range(0, 19);
        if (r == 0) send_other(CMD_CLEAR);
        else if (r == 1) send_other(CMD_NONE);
        else if (r <= 4) decode_byte(8'($urandom), 4'($urandom_range(0, 15)));
        else decode_byte(8'($urandom), BYTE_BITS);
      end

      if (round_no == 0 || $urandom_range(0, 5) == 0) drain_results();
      round_no++;
    end

    // Let the last symbols out and watch for any stray transfers.
    drain_results();
    sb.close_out();
    if (sb.failures == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
